// ----- src/cmt_pkg.sv -----
// ----------------------------------------------------------------------------
// cmt_pkg
// Shared types, constants and fixed-point helpers of the capsule tessellator.
// ----------------------------------------------------------------------------
`default_nettype none

package cmt_pkg;

  localparam int MAX_RINGS  = 64;
  localparam int MAX_SLICES = 64;
  localparam int FRAC_BITS  = 16;
  localparam int TEX_SH     = 30 - FRAC_BITS;

  localparam logic [2:0] FN_VTX_TOP  = 3'd0;
  localparam logic [2:0] FN_VTX_BOT  = 3'd1;
  localparam logic [2:0] FN_VTX_CYL  = 3'd2;
  localparam logic [2:0] FN_QUAD_TOP = 3'd3;
  localparam logic [2:0] FN_QUAD_BOT = 3'd4;
  localparam logic [2:0] FN_QUAD_CYL = 3'd5;

  localparam logic [2:0] CFG_RADIUS = 3'd0;
  localparam logic [2:0] CFG_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_RINGS  = 3'd2;
  localparam logic [2:0] CFG_SLICES = 3'd3;

  localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;
  localparam logic signed [31:0] K_C1 = 32'sd1686629713;
  localparam logic signed [31:0] K_C3 = -32'sd693598670;
  localparam logic signed [31:0] K_C5 = 32'sd85569307;
  localparam logic signed [31:0] K_C7 = -32'sd5026995;
  localparam logic signed [31:0] K_C9 = 32'sd172272;

  typedef struct packed {
    logic        quad;
    logic        cyl;
    logic        y_neg;
    logic [1:0]  kphi;
    logic [1:0]  kth;
    logic [6:0]  rings;
    logic [6:0]  slices;
    logic        ufull;
    logic        vfull;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [15:0] tri_a;
    logic [15:0] tri_b;
  } ctx_t;

  // round half away from zero
  function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + 64'h2000_0000) >> 30;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] rnd15(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + 64'h4000) >> 15;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return 32'(rnd30(p));
  endfunction

  function automatic logic [15:0] to_norm(input logic signed [31:0] q);
    logic signed [63:0] n;
    n = rnd15($signed({{32{q[31]}}, q}));
    if (n > 64'sd32767) return 16'h7fff;
    if (n < -64'sd32768) return 16'h8000;
    return n[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/capsule_mesh_tessellator.sv -----
// ----------------------------------------------------------------------------
// capsule_mesh_tessellator
// Pipelined UV capsule tessellator: vertices and quad triangles on request.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one request per transfer (func, ring index, slice index).
//   out_*  : one vertex or one triangle per transfer; last_of_run marks the
//            final result of a request.
//   cfg_*  : register writes (radius, height, ring and slice counts); always
//            ready, write only while the pipeline is empty.
// Throughput: one request per cycle while out_ready is high. A vertex gives one
//   result; a quad gives two and holds the output stage until both are taken.
// The path is set by a 5-stage angle divider (6 quotient bits per stage) and
// a 6-stage polynomial sine unit, followed by products and output rounding.
// Requests with an undefined func are taken and dropped.
// Reset empties every stage and loads the register defaults.
// When out_ready is low, results hold and stages fill behind them; in_ready
// drops only once the whole pipeline is full.
// ----------------------------------------------------------------------------
`default_nettype none

module capsule_mesh_tessellator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_func,
  input  wire logic [6:0]         in_ring_index,
  input  wire logic [6:0]         in_slice_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [26:0]      out_pos_x,
  output logic signed [26:0]      out_pos_y,
  output logic signed [26:0]      out_pos_z,
  output logic signed [15:0]      out_norm_x,
  output logic signed [15:0]      out_norm_y,
  output logic signed [15:0]      out_norm_z,
  output logic [16:0]             out_tex_u,
  output logic [16:0]             out_tex_v,
  output logic [15:0]             out_tri_first,
  output logic [15:0]             out_tri_second,
  output logic [15:0]             out_tri_third,
  output logic                    out_last_of_run,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);
  import cmt_pkg::*;

  localparam int NST = 15;

  logic [23:0] cap_radius_r, body_height_r;
  logic [6:0]  ring_count_r, slice_count_r;

  logic [NST-1:0] v_r;
  logic [NST-1:0] adv;
  ctx_t           ctx_r [NST];
  logic           phase_r;

  logic [6:0]  drem_r [6][4];
  logic [29:0] dq_r   [6][4];

  // config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_radius_r  <= 24'd65536;
      body_height_r <= 24'd131072;
      ring_count_r  <= 7'd8;
      slice_count_r <= 7'd16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RADIUS: cap_radius_r  <= cfg_data;
        CFG_HEIGHT: body_height_r <= cfg_data;
        CFG_RINGS:  ring_count_r  <= cfg_data[6:0];
        CFG_SLICES: slice_count_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // flow control
  always_comb begin
    adv[NST-1] = !v_r[NST-1] || (out_ready && (!ctx_r[NST-1].quad || phase_r));
    for (int k = NST - 2; k >= 0; k--) adv[k] = !v_r[k] || adv[k+1];
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      phase_r <= 1'b0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid && (in_func <= FN_QUAD_CYL);
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
      if (adv[NST-1]) phase_r <= 1'b0;
      else if (out_valid && out_ready && ctx_r[NST-1].quad) phase_r <= 1'b1;
    end
  end

  // front: clamps, angle quadrant, quad indices
  ctx_t       f_ctx;
  logic [6:0] f_rem [4];

  always_comb begin
    logic [6:0]  rings, slices, imax, ic, jc, iq, jq, r1, s1;
    logic [8:0]  num_p, d1, d2, d3, d4;
    logic [7:0]  num_t, e1, e2;
    logic [2:0]  kp;
    logic [1:0]  kt;
    logic [15:0] rs, base, a;
    logic        bot;
    rings  = (ring_count_r == 7'd0) ? 7'd1 :
             (ring_count_r > 7'(MAX_RINGS)) ? 7'(MAX_RINGS) : ring_count_r;
    slices = (slice_count_r == 7'd0) ? 7'd1 :
             (slice_count_r > 7'(MAX_SLICES)) ? 7'(MAX_SLICES) : slice_count_r;
    bot    = (in_func == FN_VTX_BOT);
    imax   = (in_func == FN_VTX_CYL) ? 7'd1 : rings;
    ic     = (in_ring_index > imax) ? imax : in_ring_index;
    jc     = (in_slice_index > slices) ? slices : in_slice_index;

    num_p = {jc, 2'b00};
    d1 = {2'b00, slices};
    d2 = {d1[7:0], 1'b0};
    d3 = d2 + d1;
    d4 = {d1[6:0], 2'b00};
    priority if (num_p >= d4) kp = 3'd4;
    else if (num_p >= d3) kp = 3'd3;
    else if (num_p >= d2) kp = 3'd2;
    else if (num_p >= d1) kp = 3'd1;
    else kp = 3'd0;

    num_t = {1'b0, ic} + (bot ? {1'b0, rings} : 8'd0);
    e1 = {1'b0, rings};
    e2 = {rings, 1'b0};
    priority if (num_t >= e2) kt = 2'd2;
    else if (num_t >= e1) kt = 2'd1;
    else kt = 2'd0;

    f_rem[0] = 7'(num_p - 9'(kp) * d1);
    f_rem[1] = 7'(num_t - 8'(kt) * e1);
    f_rem[2] = (jc == slices) ? 7'd0 : jc;
    f_rem[3] = (ic == rings) ? 7'd0 : ic;

    jq = (in_slice_index > slices - 7'd1) ? slices - 7'd1 : in_slice_index;
    iq = (in_ring_index > rings - 7'd1) ? rings - 7'd1 : in_ring_index;
    r1 = rings + 7'd1;
    s1 = slices + 7'd1;
    rs = 16'(r1) * 16'(s1);
    unique case (in_func)
      FN_QUAD_BOT: base = rs;
      FN_QUAD_CYL: base = {rs[14:0], 1'b0};
      default:     base = 16'd0;
    endcase
    a = base + ((in_func == FN_QUAD_CYL) ? 16'd0 : 16'(iq) * 16'(s1)) + 16'(jq);

    f_ctx.quad   = (in_func >= FN_QUAD_TOP);
    f_ctx.cyl    = (in_func == FN_VTX_CYL);
    f_ctx.y_neg  = bot || ((in_func == FN_VTX_CYL) && (ic == 7'd0));
    f_ctx.kphi   = kp[1:0];
    f_ctx.kth    = kt;
    f_ctx.rings  = rings;
    f_ctx.slices = slices;
    f_ctx.ufull  = (jc == slices);
    f_ctx.vfull  = (in_func == FN_VTX_CYL) ? (ic != 7'd0) : (ic == rings);
    f_ctx.tex_u  = '0;
    f_ctx.tex_v  = '0;
    f_ctx.tri_a  = a;
    f_ctx.tri_b  = a + 16'(s1);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ctx_r[0] <= f_ctx;
      for (int l = 0; l < 4; l++) begin
        drem_r[0][l] <= f_rem[l];
        dq_r[0][l]   <= '0;
      end
    end
  end

  // angle and texture dividers
  for (genvar s = 1; s < 6; s++) begin : g_div
    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [6:0]  den, rem_n;
      logic [29:0] hv;
      logic [5:0]  qs;
      assign den = (l % 2 == 0) ? ctx_r[s-1].slices : ctx_r[s-1].rings;
      assign hv  = (l < 2) ? 30'(den[6:1]) : (30'(den[6:1]) << TEX_SH);
      cmt_divstep u_step (
        .rem_i  (drem_r[s-1][l]),
        .den_i  (den),
        .bits_i (hv[29 - 6*(s-1) -: 6]),
        .rem_o  (rem_n),
        .q_o    (qs)
      );
      always_ff @(posedge clk) begin
        if (adv[s]) begin
          drem_r[s][l] <= rem_n;
          dq_r[s][l]   <= {dq_r[s-1][l][23:0], qs};
        end
      end
    end
  end

  for (genvar k = 1; k < 6; k++) begin : g_ctx_div
    always_ff @(posedge clk) begin
      if (adv[k]) ctx_r[k] <= ctx_r[k-1];
    end
  end

  // texture coordinates land at the sine unit entry
  ctx_t t_ctx;
  always_comb begin
    t_ctx       = ctx_r[5];
    t_ctx.tex_u = ctx_r[5].ufull ? 17'h10000 : 17'(dq_r[5][2] >> TEX_SH);
    t_ctx.tex_v = ctx_r[5].vfull ? 17'h10000 :
                  ctx_r[5].cyl   ? 17'd0 : 17'(dq_r[5][3] >> TEX_SH);
  end

  always_ff @(posedge clk) begin
    if (adv[6]) ctx_r[6] <= t_ctx;
  end

  for (genvar k = 7; k < NST; k++) begin : g_ctx_tail
    always_ff @(posedge clk) begin
      if (adv[k]) ctx_r[k] <= ctx_r[k-1];
    end
  end

  // sine unit
  logic signed [31:0] sx_in [4];
  logic signed [31:0] sy    [4];

  always_comb begin
    sx_in[0] = $signed({2'b00, dq_r[5][0]});
    sx_in[1] = Q30_ONE - $signed({2'b00, dq_r[5][0]});
    sx_in[2] = $signed({2'b00, dq_r[5][1]});
    sx_in[3] = Q30_ONE - $signed({2'b00, dq_r[5][1]});
  end

  cmt_qsine u_sine (
    .clk   (clk),
    .adv   (adv[11:6]),
    .x_in  (sx_in),
    .y_out (sy)
  );

  // quadrants and sphere direction
  logic signed [31:0] cp_r, sp_r, ct_r, sx_r, sz_r;

  always_ff @(posedge clk) begin
    if (adv[12]) begin
      logic signed [31:0] sp, cp, st, ct;
      unique case (ctx_r[11].kphi)
        2'd0: begin sp = sy[0];  cp = sy[1];  end
        2'd1: begin sp = sy[1];  cp = -sy[0]; end
        2'd2: begin sp = -sy[0]; cp = -sy[1]; end
        default: begin sp = -sy[1]; cp = sy[0]; end
      endcase
      unique case (ctx_r[11].kth)
        2'd0: begin st = sy[2];  ct = sy[3];  end
        2'd1: begin st = sy[3];  ct = -sy[2]; end
        2'd2: begin st = -sy[2]; ct = -sy[3]; end
        default: begin st = -sy[3]; ct = sy[2]; end
      endcase
      cp_r <= cp;
      sp_r <= sp;
      ct_r <= ct;
      sx_r <= mul30(st, cp);
      sz_r <= mul30(st, sp);
    end
  end

  // radius products
  logic signed [31:0] mx_r, my_r, mz_r;
  logic signed [56:0] px_r, py_r, pz_r;

  always_ff @(posedge clk) begin
    if (adv[13]) begin
      logic signed [31:0] mx, my, mz;
      logic signed [24:0] rad;
      rad = $signed({1'b0, cap_radius_r});
      mx  = ctx_r[12].cyl ? cp_r : sx_r;
      my  = ctx_r[12].cyl ? 32'sd0 : ct_r;
      mz  = ctx_r[12].cyl ? sp_r : sz_r;
      mx_r <= mx;
      my_r <= my;
      mz_r <= mz;
      px_r <= rad * mx;
      py_r <= rad * my;
      pz_r <= rad * mz;
    end
  end

  // output stage
  logic [26:0] o_px_r, o_py_r, o_pz_r;
  logic [15:0] o_nx_r, o_ny_r, o_nz_r;

  always_ff @(posedge clk) begin
    if (adv[14]) begin
      logic signed [63:0] hh, yv;
      hh = $signed({11'd0, body_height_r, 29'd0});
      yv = $signed({{7{py_r[56]}}, py_r}) + (ctx_r[13].y_neg ? -hh : hh);
      if (ctx_r[13].quad) begin
        o_px_r <= '0;
        o_py_r <= '0;
        o_pz_r <= '0;
        o_nx_r <= '0;
        o_ny_r <= '0;
        o_nz_r <= '0;
      end else begin
        o_px_r <= 27'(rnd30($signed({{7{px_r[56]}}, px_r})));
        o_py_r <= 27'(rnd30(yv));
        o_pz_r <= 27'(rnd30($signed({{7{pz_r[56]}}, pz_r})));
        o_nx_r <= to_norm(mx_r);
        o_ny_r <= to_norm(my_r);
        o_nz_r <= to_norm(mz_r);
      end
    end
  end

  assign out_valid = v_r[NST-1];

  always_comb begin
    ctx_t c;
    c = ctx_r[NST-1];
    out_pos_x  = $signed(o_px_r);
    out_pos_y  = $signed(o_py_r);
    out_pos_z  = $signed(o_pz_r);
    out_norm_x = $signed(o_nx_r);
    out_norm_y = $signed(o_ny_r);
    out_norm_z = $signed(o_nz_r);
    out_tex_u  = c.quad ? 17'd0 : c.tex_u;
    out_tex_v  = c.quad ? 17'd0 : c.tex_v;
    if (c.quad) begin
      out_tri_first   = phase_r ? c.tri_b : c.tri_a;
      out_tri_second  = phase_r ? c.tri_b + 16'd1 : c.tri_b;
      out_tri_third   = c.tri_a + 16'd1;
      out_last_of_run = phase_r;
    end else begin
      out_tri_first   = '0;
      out_tri_second  = '0;
      out_tri_third   = '0;
      out_last_of_run = 1'b1;
    end
  end

  // checks
  a_phase_quad: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (v_r[NST-1] && ctx_r[NST-1].quad))
    else $error("second triangle phase without a quad in the output stage");

  a_drop_bad_func: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_func > FN_QUAD_CYL)) |=> !v_r[0])
    else $error("undefined request entered the pipeline");

  a_vertex_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !ctx_r[NST-1].quad) |-> out_last_of_run)
    else $error("vertex result not marked last");

  a_quad_second: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && ctx_r[NST-1].quad && !phase_r) |=>
      (out_valid && phase_r))
    else $error("quad second triangle lost");

endmodule

`default_nettype wire

// ----- src/cmt_divstep.sv -----
// ----------------------------------------------------------------------------
// cmt_divstep
// Six restoring division steps on a remainder below a 7-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module cmt_divstep (
  input  wire logic [6:0] rem_i,
  input  wire logic [6:0] den_i,
  input  wire logic [5:0] bits_i,
  output logic      [6:0] rem_o,
  output logic      [5:0] q_o
);

  always_comb begin
    logic [7:0] r;
    r   = {1'b0, rem_i};
    q_o = '0;
    for (int s = 0; s < 6; s++) begin
      r = {r[6:0], bits_i[5 - s]};
      if (r >= {1'b0, den_i}) begin
        r          = r - {1'b0, den_i};
        q_o[5 - s] = 1'b1;
      end
    end
    rem_o = r[6:0];
  end

endmodule

`default_nettype wire

// ----- src/cmt_qsine.sv -----
// ----------------------------------------------------------------------------
// cmt_qsine
// Four-lane, six-stage quarter-wave sine polynomial in Q30.
// ----------------------------------------------------------------------------
`default_nettype none

module cmt_qsine (
  input  wire logic               clk,
  input  wire logic [5:0]         adv,
  input  wire logic signed [31:0] x_in [4],
  output logic signed [31:0]      y_out [4]
);
  import cmt_pkg::*;

  logic signed [31:0] lx_r  [6][4];
  logic signed [31:0] lx2_r [6][4];
  logic signed [31:0] lp_r  [6][4];
  logic signed [31:0] cf [5];

  assign cf[0] = K_C9;
  assign cf[1] = K_C7;
  assign cf[2] = K_C5;
  assign cf[3] = K_C3;
  assign cf[4] = K_C1;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int l = 0; l < 4; l++) begin
        lx_r[0][l]  <= x_in[l];
        lx2_r[0][l] <= mul30(x_in[l], x_in[l]);
        lp_r[0][l]  <= cf[0];
      end
    end
  end

  for (genvar s = 1; s < 5; s++) begin : g_horner
    always_ff @(posedge clk) begin
      if (adv[s]) begin
        for (int l = 0; l < 4; l++) begin
          lx_r[s][l]  <= lx_r[s-1][l];
          lx2_r[s][l] <= lx2_r[s-1][l];
          lp_r[s][l]  <= cf[s] + mul30(lp_r[s-1][l], lx2_r[s-1][l]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int l = 0; l < 4; l++) begin
        logic signed [31:0] p;
        p = mul30(lp_r[4][l], lx_r[4][l]);
        lx_r[5][l]  <= lx_r[4][l];
        lx2_r[5][l] <= lx2_r[4][l];
        if (p < 0) lp_r[5][l] <= '0;
        else if (p > Q30_ONE) lp_r[5][l] <= Q30_ONE;
        else lp_r[5][l] <= p;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) y_out[l] = lp_r[5][l];
  end

endmodule

`default_nettype wire

// ----- tb/capsule_mesh_tessellator_test.sv -----
// ----------------------------------------------------------------------------
// capsule_mesh_tessellator_test
// Drives vertex, quad and undefined requests under several register settings and
// random handshake gaps, predicts every vertex and triangle in fixed point and
// checks each output transfer against the prediction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module capsule_mesh_tessellator_test;
  import cmt_pkg::*;

  typedef struct packed {
    logic signed [26:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic [16:0]        u, v;
    logic [15:0]        t0, t1, t2;
    logic               last;
  } mesh_out_t;

  localparam int LATENCY   = 15;
  localparam int STALL_MAX = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_func = '0;
  logic [6:0] in_ring_index = '0, in_slice_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [26:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [15:0] out_norm_x, out_norm_y, out_norm_z;
  logic [16:0] out_tex_u, out_tex_v;
  logic [15:0] out_tri_first, out_tri_second, out_tri_third;
  logic out_last_of_run;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  mesh_out_t vertex_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int rx_wait = 0;
  logic rx_stall_off = 1'b0;

  logic [23:0] radius_r, height_r;
  logic [6:0]  rings_r, slices_r;

  always #2 clk = ~clk;

  capsule_mesh_tessellator u_top (.*);

  function automatic longint rshift(longint v, int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 << (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return rshift(a * b, 30);
  endfunction

  function automatic longint qsin(longint x);
    longint x2, p;
    x2 = fmul(x, x);
    p = 172272;
    p = -5026995 + fmul(p, x2);
    p = 85569307 + fmul(p, x2);
    p = -693598670 + fmul(p, x2);
    p = 1686629713 + fmul(p, x2);
    p = fmul(p, x);
    if (p < 0) p = 0;
    if (p > (64'sd1 << 30)) p = 64'sd1 << 30;
    return p;
  endfunction

  task automatic angle(input longint num, input longint den, output longint s,
                       output longint c);
    longint k, r, x, a, b;
    k = num / den;
    r = num - k * den;
    x = ((r << 30) + den / 2) / den;
    a = qsin(x);
    b = qsin((64'sd1 << 30) - x);
    case (k & 3)
      0: begin s = a; c = b; end
      1: begin s = b; c = -a; end
      2: begin s = -a; c = -b; end
      default: begin s = -b; c = a; end
    endcase
  endtask

  function automatic logic [15:0] unit_q15(longint q);
    longint n;
    n = rshift(q, 15);
    if (n > 32767) n = 32767;
    if (n < -32768) n = -32768;
    return n[15:0];
  endfunction

  function automatic void queue_result(input mesh_out_t r);
    vertex_q.insert(vertex_q.size(), r);
  endfunction

  task automatic predict_mesh(input logic [2:0] fn, input logic [6:0] ri,
                              input logic [6:0] sj);
    longint rings, slices, s1, r1, rad, hh, sp, cp, st, ct, sx, sz, i, j, a, b;
    mesh_out_t r;
    rings = (rings_r < 1) ? 1 : (rings_r > MAX_RINGS) ? MAX_RINGS : rings_r;
    slices = (slices_r < 1) ? 1 : (slices_r > MAX_SLICES) ? MAX_SLICES : slices_r;
    s1 = slices + 1; r1 = rings + 1;
    rad = radius_r; hh = longint'(height_r) << 29;
    i = ri; j = sj;
    if (fn > FN_QUAD_CYL) return;
    r = '0;
    if (fn <= FN_VTX_CYL) begin
      if (fn == FN_VTX_CYL) begin
        if (i > 1) i = 1;
      end else if (i > rings) i = rings;
      if (j > slices) j = slices;
      angle(4 * j, slices, sp, cp);
      r.u = 17'(((j << FRAC_BITS) + slices / 2) / slices);
      if (fn == FN_VTX_CYL) begin
        r.px = 27'(rshift(rad * cp, 30));
        r.py = 27'(rshift(i ? hh : -hh, 30));
        r.pz = 27'(rshift(rad * sp, 30));
        r.nx = unit_q15(cp);
        r.nz = unit_q15(sp);
        r.v = 17'(i << FRAC_BITS);
      end else begin
        angle(i + (fn == FN_VTX_BOT ? rings : 0), rings, st, ct);
        sx = fmul(st, cp);
        sz = fmul(st, sp);
        r.px = 27'(rshift(rad * sx, 30));
        r.py = 27'(rshift(rad * ct + (fn == FN_VTX_TOP ? hh : -hh), 30));
        r.pz = 27'(rshift(rad * sz, 30));
        r.nx = unit_q15(sx);
        r.ny = unit_q15(ct);
        r.nz = unit_q15(sz);
        r.v = 17'(((i << FRAC_BITS) + rings / 2) / rings);
      end
      r.last = 1'b1;
      queue_result(r);
    end else begin
      if (j > slices - 1) j = slices - 1;
      if (fn == FN_QUAD_CYL) a = 2 * r1 * s1 + j;
      else begin
        if (i > rings - 1) i = rings - 1;
        a = (fn - FN_QUAD_TOP) * r1 * s1 + i * s1 + j;
      end
      b = a + s1;
      r.t0 = a[15:0]; r.t1 = b[15:0]; r.t2 = 16'(a + 1); r.last = 1'b0;
      queue_result(r);
      r.t0 = b[15:0]; r.t1 = 16'(b + 1); r.t2 = 16'(a + 1); r.last = 1'b1;
      queue_result(r);
    end
  endtask

  // valid stays high after a transfer until the next gap or a drain
  task automatic send_request(input logic [2:0] fn, input logic [6:0] ri,
                              input logic [6:0] sj, input bit gaps = 1);
    int gap;
    gap = gaps ? $urandom_range(0, 13) : 0;
    if (gaps && $urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= fn; in_ring_index <= ri; in_slice_index <= sj;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_mesh(fn, ri, sj);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_RADIUS: radius_r = val;
      CFG_HEIGHT: height_r = val;
      CFG_RINGS:  rings_r = val[6:0];
      CFG_SLICES: slices_r = val[6:0];
      default: ;
    endcase
  endtask

  task automatic set_shape(input logic [23:0] rad, input logic [23:0] hgt,
                           input logic [6:0] rn, input logic [6:0] sn);
    drain_wait();
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_HEIGHT, hgt);
    write_reg(CFG_RINGS, {17'd0, rn});
    write_reg(CFG_SLICES, {17'd0, sn});
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    logic [2:0] fn;
    for (int f = 0; f < 8; f++) begin
      fn = 3'(f);
      send_request(fn, 7'd0, 7'd0);
      send_request(fn, 7'd127, 7'd127, 0);
    end
    send_request(FN_VTX_TOP, 7'd8, 7'd4);
    send_request(FN_VTX_BOT, 7'd4, 7'd16);
    send_request(FN_VTX_CYL, 7'd1, 7'd8);
    send_request(FN_QUAD_TOP, 7'd7, 7'd15);
    send_request(FN_QUAD_BOT, 7'd3, 7'd5);
    send_request(FN_QUAD_CYL, 7'd85, 7'd42);
  endtask

  task automatic test_random(input int n);
    logic [2:0] fn;
    for (int k = 0; k < n; k++) begin
      fn = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                       : 3'($urandom_range(0, 5));
      if ($urandom_range(0, 4) == 0)
        send_request(fn, 7'($urandom), 7'($urandom));
      else
        send_request(fn, 7'($urandom_range(0, rings_r + 1)),
                     7'($urandom_range(0, slices_r + 1)), k % 64 > 8);
    end
  endtask

  task automatic test_shapes();
    set_shape(24'd0, 24'd0, 7'd1, 7'd1);
    test_directed();
    test_random(60);
    set_shape(24'hffffff, 24'hffffff, 7'd64, 7'd64);
    test_directed();
    test_random(80);
    set_shape(24'd0, 24'hffffff, 7'd0, 7'd127);
    test_random(40);
    set_shape(24'h0abcde, 24'h543210, 7'd127, 7'd0);
    test_random(40);
    set_shape(24'($urandom), 24'($urandom), 7'd3, 7'd5);
    test_random(100);
  endtask

  // receiver: after a transfer, at random and unless rx_stall_off is set, wait a drawn number of cycles
  always @(posedge clk) begin
    int gap;
    gap = 0;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      if (rx_wait == 1) out_ready <= 1'b1;
    end else if (out_valid && out_ready) begin
      if (!rx_stall_off && $urandom_range(0, 1) == 0) gap = $urandom_range(0, 13);
      if (gap != 0) begin
        out_ready <= 1'b0;
        rx_wait   <= gap;
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    mesh_out_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z,
              out_tex_u, out_tex_v, out_tri_first, out_tri_second, out_tri_third,
              out_last_of_run};
      if (vertex_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer: %p", got);
      end else begin
        want = vertex_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_MAX) begin
      $display("capsule_mesh_tessellator verification failed");
      $finish;
    end
  end

  initial begin
    radius_r = 24'd65536; height_r = 24'd131072; rings_r = 7'd8; slices_r = 7'd16;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(120);
    drain_wait();
    rx_stall_off = 1'b1;
    for (int k = 0; k < 30; k++) send_request(3'($urandom_range(0, 5)),
        7'($urandom), 7'($urandom), 0);
    rx_stall_off = 1'b0;
    test_shapes();
    drain_wait();
    if (errors == 0)
      $display("capsule_mesh_tessellator verification clean");
    else
      $display("capsule_mesh_tessellator verification failed");
    $finish;
  end

endmodule

// ----- capsule_mesh_tessellator.f -----
src/cmt_pkg.sv
src/cmt_divstep.sv
src/cmt_qsine.sv
src/capsule_mesh_tessellator.sv
tb/capsule_mesh_tessellator_test.sv
